### rtl/core/m3acc_pkg.sv
// ----------------------------------------------------------------------------
// m3acc_pkg
// Shared types, command codes and status codes for the 3x3 accumulator unit.
// ----------------------------------------------------------------------------
`default_nettype none

package m3acc_pkg;

  localparam int ElemWidth = 32;
  localparam int FracBits  = 16;
  localparam int NumElem   = 9;

  typedef logic signed [ElemWidth-1:0] elem_t;

  typedef enum logic [3:0] {
    CMD_LOAD      = 4'd0,
    CMD_ADD       = 4'd1,
    CMD_SUB       = 4'd2,
    CMD_SCALE     = 4'd3,
    CMD_DIVIDE    = 4'd4,
    CMD_MATMUL    = 4'd5,
    CMD_TRANSPOSE = 4'd6,
    CMD_MATVEC    = 4'd7,
    CMD_SET_ELEM  = 4'd8,
    CMD_SET_ROW   = 4'd9,
    CMD_SET_COL   = 4'd10,
    CMD_READ      = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_DIVZ = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0] command;
    logic [1:0] row_sel;
    logic [1:0] col_sel;
    elem_t e0; elem_t e1; elem_t e2;
    elem_t e3; elem_t e4; elem_t e5;
    elem_t e6; elem_t e7; elem_t e8;
  } in_beat_t;

  typedef struct packed {
    elem_t m0; elem_t m1; elem_t m2;
    elem_t m3; elem_t m4; elem_t m5;
    elem_t m6; elem_t m7; elem_t m8;
    logic [1:0] status;
  } out_beat_t;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_sts_t;

  localparam logic signed [ElemWidth-1:0] ElemMax = {1'b0, {(ElemWidth-1){1'b1}}};
  localparam logic signed [ElemWidth-1:0] ElemMin = {1'b1, {(ElemWidth-1){1'b0}}};

  // saturate a 34-bit signed sum to an element
  function automatic elem_t sat_sum(input logic signed [ElemWidth+1:0] v,
                                    output logic sat);
    logic signed [ElemWidth+1:0] lo_lim;
    logic signed [ElemWidth+1:0] hi_lim;
    begin
      lo_lim = {{2{1'b1}}, ElemMin};
      hi_lim = {2'b00, ElemMax};
      sat = 1'b0;
      if (v > hi_lim) begin
        sat = 1'b1;
        sat_sum = ElemMax;
      end else if (v < lo_lim) begin
        sat = 1'b1;
        sat_sum = ElemMin;
      end else begin
        sat_sum = v[ElemWidth-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/matrix3_accumulator_unit.sv
// ----------------------------------------------------------------------------
// matrix3_accumulator_unit
// 3x3 signed Q16.16 accumulator matrix with a shared multiplier and divider.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_ready   | in_data  (in_beat_t)
//  out     | out | out_valid/out_ready | out_data (out_beat_t)
//
// One beat at a time; in_ready is low from accept until the result is taken.
// Element-wise commands step through the elements; scale takes one MAC
// product each, matmul three, matvec three for each of its three results.
// Divide uses the one-bit-per-cycle divider. Reset clears the matrix to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix3_accumulator_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire m3acc_pkg::in_beat_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output m3acc_pkg::out_beat_t       out_data
);
  import m3acc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ELEM = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_RES  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  elem_t mat [NumElem];
  elem_t res [NumElem];
  elem_t op  [NumElem];
  cmd_t  cmd;
  logic [1:0] rs, cs;
  logic [3:0] idx;
  logic [1:0] k;
  logic [1:0] mstep;
  logic       sat_f, bad_f, dz_f;

  // operand latch on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_t'(in_data.command);
      rs  <= in_data.row_sel;
      cs  <= in_data.col_sel;
      op[0] <= in_data.e0; op[1] <= in_data.e1; op[2] <= in_data.e2;
      op[3] <= in_data.e3; op[4] <= in_data.e4; op[5] <= in_data.e5;
      op[6] <= in_data.e6; op[7] <= in_data.e7; op[8] <= in_data.e8;
    end
  end

  // row/column of current element
  logic [1:0] row_i, col_i;
  assign row_i = (idx >= 4'd6) ? 2'd2 : (idx >= 4'd3) ? 2'd1 : 2'd0;
  assign col_i = 2'(idx - 4'(row_i) * 4'd3);

  // MAC operand selection
  elem_t mac_a, mac_b, mac_res;
  logic  mac_sat, mac_clear, mac_mul, mac_acc;
  always_comb begin
    mac_a = mat[idx];
    mac_b = op[0];
    case (cmd)
      CMD_MATMUL: begin
        mac_a = mat[4'(row_i) * 4'd3 + 4'(k)];
        mac_b = op[4'(k) * 4'd3 + 4'(col_i)];
      end
      CMD_MATVEC: begin
        mac_a = mat[idx * 4'd3 + 4'(k)];
        mac_b = op[4'(k)];
      end
      default: ;
    endcase
  end

  logic [1:0] nterms;
  assign nterms = (cmd == CMD_SCALE) ? 2'd1 : 2'd3;
  assign mac_clear = (state == S_ELEM);
  assign mac_mul   = (state == S_MUL);
  assign mac_acc   = (state == S_ACC) || (state == S_MUL && mstep != 2'd0);

  m3acc_mac u_mac (
    .clk(clk), .clear(mac_clear), .mul_en(mac_mul), .acc_en(mac_acc),
    .a(mac_a), .b(mac_b), .result(mac_res), .sat(mac_sat)
  );

  // divider
  div_ctl_t div_ctl;
  div_sts_t div_sts;
  elem_t    div_q;
  logic [ElemWidth-1:0] mag_a, mag_s;
  assign mag_a = mat[idx][ElemWidth-1] ? ElemWidth'(-mat[idx]) : mat[idx];
  assign mag_s = op[0][ElemWidth-1] ? ElemWidth'(-op[0]) : op[0];
  logic div_go;
  assign div_ctl.start = div_go;
  assign div_ctl.neg   = mat[idx][ElemWidth-1] ^ op[0][ElemWidth-1];

  m3acc_divider u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .mag_a(mag_a), .mag_s(mag_s),
    .sts(div_sts), .quot(div_q)
  );

  // element-wise value for simple commands
  elem_t ew_val;
  logic  ew_sat, ew_bad;
  logic signed [ElemWidth+1:0] ew_sum;
  always_comb begin
    ew_val = mat[idx];
    ew_sat = 1'b0;
    ew_bad = 1'b0;
    ew_sum = '0;
    case (cmd)
      CMD_LOAD: ew_val = op[idx];
      CMD_ADD: begin
        ew_sum = (ElemWidth+2)'(mat[idx]) + (ElemWidth+2)'(op[idx]);
        ew_val = sat_sum(ew_sum, ew_sat);
      end
      CMD_SUB: begin
        ew_sum = (ElemWidth+2)'(mat[idx]) - (ElemWidth+2)'(op[idx]);
        ew_val = sat_sum(ew_sum, ew_sat);
      end
      CMD_TRANSPOSE: ew_val = mat[4'(col_i) * 4'd3 + 4'(row_i)];
      CMD_SET_ELEM: begin
        ew_bad = (rs == 2'd0) || (cs == 2'd0);
        if (!ew_bad && row_i == rs - 2'd1 && col_i == cs - 2'd1) ew_val = op[0];
      end
      CMD_SET_ROW: begin
        ew_bad = (rs == 2'd0);
        if (!ew_bad && row_i == rs - 2'd1) ew_val = op[4'(col_i)];
      end
      CMD_SET_COL: begin
        ew_bad = (cs == 2'd0);
        if (!ew_bad && col_i == cs - 2'd1) ew_val = op[4'(row_i)];
      end
      CMD_READ: ;
      default: ew_bad = 1'b1;
    endcase
  end

  logic is_mac, is_div, last_idx;
  assign is_mac   = (cmd == CMD_SCALE) || (cmd == CMD_MATMUL) || (cmd == CMD_MATVEC);
  assign is_div   = (cmd == CMD_DIVIDE) && (op[0] != '0);
  assign last_idx = (cmd == CMD_MATVEC) ? (idx == 4'd2) : (idx == 4'd8);
  assign div_go   = (state == S_ELEM) && is_div;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NumElem; i++) mat[i] <= '0;
      idx <= '0; k <= '0; mstep <= '0;
      sat_f <= 1'b0; bad_f <= 1'b0; dz_f <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_ELEM;
          idx <= '0;
          sat_f <= 1'b0; bad_f <= 1'b0; dz_f <= 1'b0;
        end
        S_ELEM: begin
          k <= '0; mstep <= '0;
          if (is_mac) state <= S_MUL;
          else if (is_div) state <= S_DIV;
          else begin
            if (cmd == CMD_DIVIDE) begin
              dz_f <= 1'b1;
              res[idx] <= (mat[idx] == '0) ? '0 : (mat[idx][ElemWidth-1] ? ElemMin : ElemMax);
            end else begin
              res[idx] <= ew_val;
              sat_f <= sat_f | ew_sat;
              bad_f <= bad_f | ew_bad;
            end
            if (last_idx) state <= S_OUT;
            else idx <= idx + 4'd1;
          end
        end
        S_MUL: begin
          mstep <= 2'd1;
          if (k == nterms - 2'd1) state <= S_ACC;
          else k <= k + 2'd1;
        end
        // last product enters the accumulator
        S_ACC: state <= S_RES;
        // MAC result is taken in the cycle after the last accumulate
        S_RES: begin
          res[idx] <= mac_res;
          sat_f <= sat_f | mac_sat;
          if (last_idx) state <= S_OUT;
          else begin
            idx <= idx + 4'd1;
            state <= S_ELEM;
          end
        end
        S_DIV: if (div_sts.done) begin
          res[idx] <= div_q;
          sat_f <= sat_f | div_sts.sat;
          if (last_idx) state <= S_OUT;
          else begin
            idx <= idx + 4'd1;
            state <= S_ELEM;
          end
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
          if (cmd != CMD_MATVEC && !bad_f)
            for (int i = 0; i < NumElem; i++) mat[i] <= res[i];
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // output beat
  always_comb begin
    out_data.m0 = res[0]; out_data.m1 = res[1]; out_data.m2 = res[2];
    out_data.m3 = res[3]; out_data.m4 = res[4]; out_data.m5 = res[5];
    out_data.m6 = res[6]; out_data.m7 = res[7]; out_data.m8 = res[8];
    if (cmd == CMD_MATVEC) begin
      out_data.m3 = '0; out_data.m4 = '0; out_data.m5 = '0;
      out_data.m6 = '0; out_data.m7 = '0; out_data.m8 = '0;
    end
    if (bad_f)      out_data.status = ST_BAD;
    else if (dz_f)  out_data.status = ST_DIVZ;
    else if (sat_f) out_data.status = ST_SAT;
    else            out_data.status = ST_OK;
    if (bad_f) begin
      out_data.m0 = mat[0]; out_data.m1 = mat[1]; out_data.m2 = mat[2];
      out_data.m3 = mat[3]; out_data.m4 = mat[4]; out_data.m5 = mat[5];
      out_data.m6 = mat[6]; out_data.m7 = mat[7]; out_data.m8 = mat[8];
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_ELEM)
    else $error("accept did not start work");
  assert property (@(posedge clk) disable iff (rst) state == S_DIV |-> is_div)
    else $error("divide state without divisor");

endmodule

`default_nettype wire

### rtl/core/m3acc_divider.sv
// ----------------------------------------------------------------------------
// m3acc_divider
// Radix-2 restoring divider for fixed-point quotient |a|/|s| with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module m3acc_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire m3acc_pkg::div_ctl_t            ctl,
  input  wire logic [m3acc_pkg::ElemWidth-1:0] mag_a,
  input  wire logic [m3acc_pkg::ElemWidth-1:0] mag_s,
  output m3acc_pkg::div_sts_t                 sts,
  output m3acc_pkg::elem_t                    quot
);
  import m3acc_pkg::*;

  localparam int QW   = ElemWidth + FracBits;
  localparam int CntW = $clog2(QW + 1);

  // remainder stays below the divisor, quotient full width
  logic [ElemWidth-1:0] rem;
  logic [QW-1:0]        q;
  logic [QW-1:0]        num;
  logic [ElemWidth-1:0] dvs;
  logic [CntW-1:0]      cnt;
  logic                 busy;
  logic                 neg;
  logic [ElemWidth:0]   trial;
  logic                 fin;

  assign trial = {rem, num[QW-1]};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CntW'(QW);
        rem  <= '0;
        q    <= '0;
        num  <= {mag_a, {FracBits{1'b0}}};
        dvs  <= mag_s;
        neg  <= ctl.neg;
      end else if (busy) begin
        num <= {num[QW-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= ElemWidth'(trial - {1'b0, dvs});
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= trial[ElemWidth-1:0];
          q   <= {q[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // saturate signed result
  always_comb begin
    sts.done = fin;
    sts.sat  = 1'b0;
    if (neg) begin
      if (q > {{FracBits{1'b0}}, 1'b1, {(ElemWidth-1){1'b0}}}) begin
        sts.sat = 1'b1;
        quot = ElemMin;
      end else begin
        quot = elem_t'(-q[ElemWidth-1:0]);
      end
    end else begin
      if (q > {{(FracBits+1){1'b0}}, {(ElemWidth-1){1'b1}}}) begin
        sts.sat = 1'b1;
        quot = ElemMax;
      end else begin
        quot = elem_t'(q[ElemWidth-1:0]);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) fin |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider count underflow");

endmodule

`default_nettype wire

### rtl/core/m3acc_mac.sv
// ----------------------------------------------------------------------------
// m3acc_mac
// Shared signed multiplier with product register and wide accumulator;
// rounds half up and saturates the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module m3acc_mac (
  input  wire logic              clk,
  input  wire logic              clear,
  input  wire logic              mul_en,
  input  wire logic              acc_en,
  input  wire m3acc_pkg::elem_t  a,
  input  wire m3acc_pkg::elem_t  b,
  output m3acc_pkg::elem_t       result,
  output logic                   sat
);
  import m3acc_pkg::*;

  localparam int PW = 2 * ElemWidth;
  localparam int AW = PW + 2;

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] rnd;
  logic signed [AW-FracBits-1:0] shf;

  // product register, then accumulate
  always_ff @(posedge clk) begin
    if (mul_en) prod <= a * b;
    if (clear) acc <= '0;
    else if (acc_en) acc <= acc + AW'(prod);
  end

  // round half up and saturate
  always_comb begin
    rnd = acc + (AW'(1) <<< (FracBits - 1));
    shf = rnd[AW-1:FracBits];
    sat = 1'b0;
    if (shf > (AW-FracBits)'(ElemMax)) begin
      sat = 1'b1;
      result = ElemMax;
    end else if (shf < (AW-FracBits)'(ElemMin)) begin
      sat = 1'b1;
      result = ElemMin;
    end else begin
      result = shf[ElemWidth-1:0];
    end
  end

endmodule

`default_nettype wire
